// ===== sv/sonar_beam_peak_grouper_assert.svh =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper: assertion macros
// Shared concurrent assertion forms used by the grouper RTL.
// ---------------------------------------------------------------------------
`ifndef SONAR_BEAM_PEAK_GROUPER_ASSERT_SVH
`define SONAR_BEAM_PEAK_GROUPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SBPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sonar beam peak grouper: assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SBPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sonar beam peak grouper: assertion failed");

`endif

// ===== sv/sbpg_pkg.sv =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper: package
// Widths, register indices and the word types passed between the modules.
// ---------------------------------------------------------------------------
package sbpg_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int BIN_W      = 10;
    localparam int GAP_W      = 9;
    localparam int GAP_VAL_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_ADDR_W = 2;

    localparam logic [GAP_W-1:0] GAP_MAX = 9'd511;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_BIN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_GAP   = 2'd2;

    localparam logic [SAMPLE_W-1:0]  RST_THRESHOLD = 8'd20;
    localparam logic [BIN_W-1:0]     RST_START_BIN = 10'd2;
    localparam logic [GAP_VAL_W-1:0] RST_MIN_GAP   = 8'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  threshold;
        logic [BIN_W-1:0]     start_bin;
        logic [GAP_VAL_W-1:0] min_gap;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                beam_end;
    } t_in_word;

    typedef struct packed {
        logic [BIN_W-1:0] peak_bin;
        logic             peak_valid;
        logic             last;
    } t_result;

endpackage

// ===== sv/sbpg_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper: configuration registers
// Holds the threshold, start bin and minimum gap written over the plain
// write port.
// ---------------------------------------------------------------------------
module sbpg_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sbpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sbpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output sbpg_pkg::t_cfg                  o_cfg
);
    import sbpg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD: n_cfg.threshold = i_cfg_wdata[SAMPLE_W-1:0];
                CFG_START_BIN: n_cfg.start_bin = i_cfg_wdata[BIN_W-1:0];
                CFG_MIN_GAP:   n_cfg.min_gap   = i_cfg_wdata[GAP_VAL_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= RST_THRESHOLD;
            r_cfg.start_bin <= RST_START_BIN;
            r_cfg.min_gap   <= RST_MIN_GAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/sbpg_in_reg.sv =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper: input register
// Captures one input word and holds it until the grouping stage takes it.
// ---------------------------------------------------------------------------
module sbpg_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  sbpg_pkg::t_in_word i_word,
    input  logic               i_take,
    output logic               o_valid,
    output sbpg_pkg::t_in_word o_word
);
    import sbpg_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_word r_word;
    logic     accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= i_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== sv/sbpg_core.sv =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper: grouping core
// Holds the per-beam state and works out, for one bin, the state update and
// the result word it causes.
// ---------------------------------------------------------------------------
`include "sonar_beam_peak_grouper_assert.svh"

module sbpg_core #(
    parameter logic [9:0] BIN_LIMIT = 10'd1023
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbpg_pkg::t_cfg     i_cfg,
    input  logic               i_fire,
    input  sbpg_pkg::t_in_word i_word,
    output logic               o_res_valid,
    output sbpg_pkg::t_result  o_res
);
    import sbpg_pkg::*;

    logic [BIN_W-1:0]    r_bin_count;
    logic [BIN_W-1:0]    n_bin_count;
    logic [GAP_W-1:0]    r_gap_count;
    logic [GAP_W-1:0]    n_gap_count;
    logic                r_group_open;
    logic                n_group_open;
    logic [SAMPLE_W-1:0] r_peak_value;
    logic [SAMPLE_W-1:0] n_peak_value;
    logic [BIN_W-1:0]    r_peak_bin;
    logic [BIN_W-1:0]    n_peak_bin;

    logic             considered;
    logic             above;
    logic [GAP_W-1:0] gap_inc;
    logic             update_peak;
    logic             close_group;
    logic             open_mid;
    logic             emit;

    assign considered  = r_bin_count >= i_cfg.start_bin;
    assign above       = i_word.sample > i_cfg.threshold;
    assign gap_inc     = (r_gap_count < GAP_MAX) ? r_gap_count + 1'b1 : r_gap_count;
    assign update_peak = considered && above
                         && (!r_group_open || i_word.sample > r_peak_value);
    assign close_group = considered && !above && r_group_open
                         && (gap_inc == {1'b0, i_cfg.min_gap});
    assign open_mid    = close_group ? 1'b0 : (update_peak ? 1'b1 : r_group_open);
    assign emit        = close_group || (i_word.beam_end && open_mid);

    always_comb begin
        n_bin_count  = (r_bin_count < BIN_LIMIT) ? r_bin_count + 1'b1 : r_bin_count;
        n_gap_count  = r_gap_count;
        n_group_open = open_mid;
        n_peak_value = r_peak_value;
        n_peak_bin   = r_peak_bin;
        if (considered) begin
            n_gap_count = above ? '0 : gap_inc;
        end
        if (update_peak) begin
            n_peak_value = i_word.sample;
            n_peak_bin   = r_bin_count;
        end
        if (close_group) begin
            n_peak_value = '0;
        end
        if (i_word.beam_end) begin
            n_bin_count  = '0;
            n_gap_count  = {1'b0, i_cfg.min_gap} + 1'b1;
            n_group_open = 1'b0;
            n_peak_value = '0;
            n_peak_bin   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_count  <= '0;
            r_gap_count  <= {1'b0, RST_MIN_GAP} + 1'b1;
            r_group_open <= 1'b0;
            r_peak_value <= '0;
            r_peak_bin   <= '0;
        end else if (i_fire) begin
            r_bin_count  <= n_bin_count;
            r_gap_count  <= n_gap_count;
            r_group_open <= n_group_open;
            r_peak_value <= n_peak_value;
            r_peak_bin   <= n_peak_bin;
        end
    end

    assign o_res_valid      = emit || i_word.beam_end;
    assign o_res.peak_bin   = emit ? (update_peak ? r_bin_count : r_peak_bin) : '0;
    assign o_res.peak_valid = emit;
    assign o_res.last       = i_word.beam_end;

    `SBPG_ASSERT_IMPL(a_bin_capped, i_clk, i_rst_n, 1'b1, r_bin_count <= BIN_LIMIT)
    `SBPG_ASSERT_NEXT(a_beam_restart, i_clk, i_rst_n, i_fire && i_word.beam_end,
        r_bin_count == '0 && !r_group_open)
    `SBPG_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !i_fire,
        $stable(r_bin_count) && $stable(r_gap_count) && $stable(r_group_open))

endmodule

// ===== sv/sbpg_out_reg.sv =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper: output register
// Holds one result word until the downstream side takes it.
// ---------------------------------------------------------------------------
module sbpg_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sbpg_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_stall,
    output sbpg_pkg::t_result o_res
);
    import sbpg_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sv/sonar_beam_peak_grouper.sv =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper
// Groups above-threshold echo samples of a sonar beam and reports the bin of
// each group's strongest sample, with an end marker on the final bin.
//
//   Channel  Direction  Handshake                  Word
//   in       input      i_in_valid / o_in_stall    i_intensity, i_beam_end
//   out      output     o_out_valid / i_out_stall  o_peak_bin, o_peak_valid, o_last
//   cfg      input      i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// One word is accepted per cycle unless the output stalls; the grouping core runs
// between the input and output registers, so a result is presented by the output
// register once its word has passed the input register and the core. Reset is
// synchronous, active low, and restores the register defaults and an empty beam.
// An output stall holds the result register and backs up into the input register.
// ---------------------------------------------------------------------------
`include "sonar_beam_peak_grouper_assert.svh"

module sonar_beam_peak_grouper #(
    parameter int MAX_BINS    = 1024,
    parameter int SAMPLE_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [sbpg_pkg::SAMPLE_W-1:0]   i_intensity,
    input  logic                            i_beam_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sbpg_pkg::BIN_W-1:0]      o_peak_bin,
    output logic                            o_peak_valid,
    output logic                            o_last,
    input  logic                            i_cfg_we,
    input  logic [sbpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [sbpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import sbpg_pkg::*;

    localparam int LIMIT_INT = (MAX_BINS - 1 > 1023) ? 1023 : MAX_BINS - 1;
    localparam logic [BIN_W-1:0] BIN_LIMIT = LIMIT_INT[BIN_W-1:0];
    localparam int MASK_BITS = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_W : SAMPLE_BITS;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << MASK_BITS) - 1);

    t_cfg     cfg;
    t_in_word in_word;
    t_in_word core_word;
    logic     core_valid;
    logic     out_free;
    logic     fire;
    logic     res_valid;
    t_result  core_res;
    t_result  out_res;

    assign in_word.sample   = i_intensity & SAMPLE_MASK;
    assign in_word.beam_end = i_beam_end;
    assign fire             = core_valid && out_free;

    sbpg_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sbpg_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_word  (in_word),
        .i_take  (fire),
        .o_valid (core_valid),
        .o_word  (core_word)
    );

    sbpg_core #(
        .BIN_LIMIT (BIN_LIMIT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (fire),
        .i_word      (core_word),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    sbpg_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (core_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (out_res)
    );

    assign o_peak_bin   = out_res.peak_bin;
    assign o_peak_valid = out_res.peak_valid;
    assign o_last       = out_res.last;

    `SBPG_ASSERT_IMPL(a_marker_is_last, i_clk, i_rst_n, o_out_valid && !o_peak_valid, o_last)
    `SBPG_ASSERT_IMPL(a_marker_bin_zero, i_clk, i_rst_n, o_out_valid && !o_peak_valid,
        o_peak_bin == '0)
    `SBPG_ASSERT_IMPL(a_stall_needs_word, i_clk, i_rst_n, o_in_stall,
        core_valid && o_out_valid && i_out_stall)

endmodule

// ===== tb/sv/sonar_beam_peak_grouper_tb.sv =====
// ---------------------------------------------------------------------------
// Sonar beam peak grouper: testbench
// Streams echo words through the grouper under random idling on both sides,
// predicts every result with a local model of the grouping rules and checks
// each emitted word field by field, across several register settings.
// ---------------------------------------------------------------------------
module sonar_beam_peak_grouper_tb;

    import sbpg_pkg::*;

    localparam int MAX_BINS   = 1024;
    localparam int BIN_LIMIT  = (MAX_BINS - 1 > 1023) ? 1023 : MAX_BINS - 1;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 80;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [SAMPLE_W-1:0]   i_intensity = '0;
    logic                  i_beam_end  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BIN_W-1:0]      o_peak_bin;
    logic                  o_peak_valid;
    logic                  o_last;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    sonar_beam_peak_grouper #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (8)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_intensity  (i_intensity),
        .i_beam_end   (i_beam_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_peak_bin   (o_peak_bin),
        .o_peak_valid (o_peak_valid),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_word echo_queue[$];
    t_result  peaks_due[$];
    t_in_word nxt_word;
    t_result  want;

    t_cfg             cfg_model;
    logic [BIN_W-1:0] bin_idx;
    logic [GAP_W-1:0] gap_run;
    logic             grp_open;
    logic [SAMPLE_W-1:0] grp_peak;
    logic [BIN_W-1:0] grp_bin;

    int err_count  = 0;
    int idle_run   = 0;
    int send_wait  = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_req   = 1'b0;
    bit steady     = 1'b0;
    bit in_fire    = 1'b0;
    bit out_fire   = 1'b0;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void restart_beam();
        bin_idx  = '0;
        gap_run  = {1'b0, cfg_model.min_gap} + 9'd1;
        grp_open = 1'b0;
        grp_peak = '0;
        grp_bin  = '0;
    endfunction

    // Advances the grouping state by one word and queues the result it causes.
    function automatic void track_echo(input t_in_word w);
        logic             fire;
        logic [BIN_W-1:0] fire_bin;
        t_result          r;
        fire     = 1'b0;
        fire_bin = '0;
        if (bin_idx >= cfg_model.start_bin) begin
            if (w.sample > cfg_model.threshold) begin
                gap_run = '0;
                if (!grp_open || w.sample > grp_peak) begin
                    grp_peak = w.sample;
                    grp_bin  = bin_idx;
                    grp_open = 1'b1;
                end
            end else begin
                if (gap_run < GAP_MAX) gap_run = gap_run + 9'd1;
                if (gap_run == {1'b0, cfg_model.min_gap} && grp_open) begin
                    fire     = 1'b1;
                    fire_bin = grp_bin;
                    grp_open = 1'b0;
                    grp_peak = '0;
                end
            end
        end
        if (bin_idx < BIN_LIMIT) bin_idx = bin_idx + 10'd1;
        if (w.beam_end) begin
            if (!fire && grp_open) begin
                fire     = 1'b1;
                fire_bin = grp_bin;
            end
            r.peak_bin   = fire ? fire_bin : '0;
            r.peak_valid = fire;
            r.last       = 1'b1;
            peaks_due.insert(peaks_due.size(), r);
            restart_beam();
        end else if (fire) begin
            r.peak_bin   = fire_bin;
            r.peak_valid = 1'b1;
            r.last       = 1'b0;
            peaks_due.insert(peaks_due.size(), r);
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_echo(input int thr);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 30) v = thr + $urandom_range(1, 40);
        else if (r < 38) v = thr;
        else if (r < 44) v = thr + 1;
        else if (r < 75) v = $urandom_range(0, thr);
        else if (r < 88) v = $urandom_range(0, 255);
        else if (r < 94) v = 255;
        else v = 0;
        if (v > 255) v = 255;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic queue_bin(input int v, input bit fin);
        t_in_word w;
        w.sample   = v[SAMPLE_W-1:0];
        w.beam_end = fin;
        echo_queue.insert(echo_queue.size(), w);
    endtask

    task automatic queue_beam(input int len, input bit closed);
        for (int k = 0; k < len; k++) begin
            queue_bin(draw_echo(cfg_model.threshold), closed && (k == len - 1));
        end
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_THRESHOLD: cfg_model.threshold = val[SAMPLE_W-1:0];
            CFG_START_BIN: cfg_model.start_bin = val[BIN_W-1:0];
            CFG_MIN_GAP:   cfg_model.min_gap   = val[GAP_VAL_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every word has gone in and every result has come out, then
    // lets the pipeline run empty, since words with no result may still be in it.
    task automatic wait_idle();
        while (echo_queue.size() != 0 || i_in_valid || peaks_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (send_wait > 0) begin
                i_in_valid <= 1'b0;
                send_wait--;
            end else if (echo_queue.size() != 0) begin
                nxt_word = echo_queue.pop_front();
                i_intensity <= nxt_word.sample;
                i_beam_end  <= nxt_word.beam_end;
                i_in_valid  <= 1'b1;
                send_wait = steady ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            stall_left = (steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
            i_out_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        in_fire  = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (out_fire) begin
            if (peaks_due.size() == 0) begin
                flag_error($sformatf("unexpected word: bin %0d valid %0b last %0b",
                                     o_peak_bin, o_peak_valid, o_last));
            end else begin
                want = peaks_due.pop_front();
                if (o_peak_bin !== want.peak_bin)
                    flag_error($sformatf("peak_bin %0d, expected %0d",
                                         o_peak_bin, want.peak_bin));
                if (o_peak_valid !== want.peak_valid)
                    flag_error($sformatf("peak_valid %0b, expected %0b",
                                         o_peak_valid, want.peak_valid));
                if (o_last !== want.last)
                    flag_error($sformatf("last %0b, expected %0b", o_last, want.last));
            end
        end
        if (in_fire) begin
            nxt_word.sample   = i_intensity;
            nxt_word.beam_end = i_beam_end;
            track_echo(nxt_word);
        end
        if (!i_rst_n || in_fire || out_fire) begin
            idle_run = 0;
        end else begin
            idle_run++;
            if (idle_run >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("sonar_beam_peak_grouper_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int len;
        int nbeams;
        int rand_words;
        cfg_model.threshold = RST_THRESHOLD;
        cfg_model.start_bin = RST_START_BIN;
        cfg_model.min_gap   = RST_MIN_GAP;
        restart_beam();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Skipped bins, ties, a gap closing a group, a gap with no group, flush.
        queue_bin(255, 0); queue_bin(255, 0); queue_bin(21, 0); queue_bin(30, 0);
        queue_bin(30, 0);  queue_bin(20, 0);  queue_bin(0, 0);  queue_bin(0, 0);
        queue_bin(0, 0);   queue_bin(255, 0); queue_bin(25, 1);
        // The final bin closes a group, then a lone skipped final bin, then a bare marker.
        queue_bin(0, 0); queue_bin(0, 0); queue_bin(50, 0); queue_bin(0, 0);
        queue_bin(0, 0); queue_bin(0, 1);
        queue_bin(255, 1);
        queue_bin(0, 0); queue_bin(7, 0); queue_bin(20, 1);
        wait_idle();

        // The receiver holds off while short beams arrive back to back.
        steady   = 1'b1;
        hold_req = 1'b1;
        for (int b = 0; b < 40; b++) queue_beam($urandom_range(1, 2), 1'b1);
        wait_idle();
        steady = 1'b0;

        // A long beam: the gap counter and then the bin index saturate.
        set_reg(CFG_THRESHOLD, 100);
        set_reg(CFG_START_BIN, 0);
        set_reg(CFG_MIN_GAP, 4);
        for (int k = 0; k < 600; k++) queue_bin($urandom_range(0, 100), 1'b0);
        for (int k = 0; k < 410; k++) queue_bin(draw_echo(100), 1'b0);
        wait_idle();
        set_reg(CFG_START_BIN, 1023);
        queue_beam(30, 1'b1);
        wait_idle();

        // An open group is flushed by a final bin that lies below the start bin.
        set_reg(CFG_THRESHOLD, 0);
        set_reg(CFG_START_BIN, 0);
        set_reg(CFG_MIN_GAP, 1);
        queue_bin(5, 0); queue_bin(9, 0);
        wait_idle();
        set_reg(CFG_START_BIN, 1023);
        queue_bin(255, 1);
        wait_idle();

        set_reg(CFG_THRESHOLD, 255);
        set_reg(CFG_START_BIN, 0);
        set_reg(CFG_MIN_GAP, 255);
        for (int b = 0; b < 4; b++) queue_beam($urandom_range(3, 6), 1'b1);
        wait_idle();

        rand_words = 0;
        while (rand_words < 200) begin
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 9);
                set_reg(CFG_THRESHOLD, r == 0 ? 0 : r == 1 ? 255 : $urandom_range(5, 60));
            end
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 9);
                set_reg(CFG_START_BIN, r == 0 ? 0 : $urandom_range(0, 10));
            end
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 9);
                set_reg(CFG_MIN_GAP, r == 0 ? 1 : r == 1 ? 255 : $urandom_range(1, 6));
            end
            steady = ($urandom_range(0, 3) == 0);
            nbeams = $urandom_range(2, 6);
            for (int b = 0; b < nbeams; b++) begin
                r = $urandom_range(0, 9);
                if (r < 8) len = $urandom_range(1, cfg_model.start_bin + 25);
                else if (r < 9) len = $urandom_range(1, 3);
                else len = $urandom_range(40, 80);
                queue_beam(len, (b != nbeams - 1) || ($urandom_range(0, 99) < 85));
                rand_words += len;
            end
            wait_idle();
        end
        steady = 1'b0;

        repeat (10) @(posedge i_clk);
        if (peaks_due.size() != 0)
            flag_error($sformatf("%0d expected words never arrived", peaks_due.size()));
        if (err_count == 0) begin
            $display("sonar_beam_peak_grouper_tb: done, clean");
        end else begin
            $display("sonar_beam_peak_grouper_tb: done, errors");
        end
        $finish;
    end

endmodule
